@@ rtl/core/tcb_pkg.sv @@
package tcb_pkg;

  localparam int TS_W       = 48;
  localparam int E_W        = 16;
  localparam int CH_W       = 4;
  localparam int IDX_W      = 4;
  localparam int WIN_W      = TS_W + 2;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 104;
  localparam int ADDR_W     = 3;
  localparam int APB_W      = 32;

  localparam logic [CH_W-1:0] CH_DET0 = 4'd0;
  localparam logic [CH_W-1:0] CH_DET1 = 4'd1;
  localparam logic [CH_W-1:0] CH_TAC  = 4'd2;

  localparam logic REG_HALF_WIDTH = 1'b0;
  localparam logic REG_OFFSET     = 1'b1;

  localparam logic [E_W-1:0] HALF_WIDTH_RST = 16'd50;
  localparam logic [E_W-1:0] OFFSET_RST     = 16'hFED4;

  typedef struct packed {
    logic            ch;
    logic [TS_W-1:0] time_v;
    logic [E_W-1:0]  energy;
    logic [E_W-1:0]  short_energy;
    logic            match;
  } hit_t;

  typedef struct packed {
    logic load;
    logic take;
    logic calc;
  } cell_ctl_t;

endpackage

@@ rtl/core/timestamp_coincidence_builder_top.sv @@
// Coincidence event builder for timestamped detector hits.
// Hit requests arrive on the in_ stream: channels 0 and 1 are detector hits,
// channel 2 is the TAC, all other channels are accepted and ignored.
// Detector hits are held in a row of DEPTH cells, oldest first; a full row
// drops its oldest hit and raises the dropped flag in out_tuser.
// A detector hit is stored and the block is ready again at once.
// A TAC hit is latched, the window is formed from it, every cell compares its
// hit in parallel, and both channels are checked; with no coincidence the
// block is then ready again. A TAC hit that forms a coincidence goes on to
// rotate the row past its output end, one cell a cycle while no result is
// stalled, and a result is sent for each matched hit as it reaches that end.
// While a result is pending and out_tready is low, the rotation waits on
// each matched hit; results are never lost, and in_tready stays low until the
// rotation has finished. Configuration is written through the cfg_ port.
// Reset clears the fill count, the flags and the pending result; it loads
// half width 50 and offset -300.
module timestamp_coincidence_builder_top #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // channel[3:0], timestamp[51:4], energy[67:52], short_energy[83:68]
  input  logic [tcb_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tac_energy[15:0], hit_channel[16], hit_time[64:17], hit_energy[80:65],
  // hit_short_energy[96:81], hit_index[100:97]
  output logic [tcb_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast,
  // hits_dropped[0]
  output logic                               out_tuser,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [tcb_pkg::ADDR_W-1:0]         cfg_paddr,
  input  logic [tcb_pkg::APB_W-1:0]          cfg_pwdata,
  output logic [tcb_pkg::APB_W-1:0]          cfg_prdata,
  output logic                               cfg_pready
);
  import tcb_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WIN    = 3'd1;
  localparam logic [2:0] S_CALC   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    tac_seen_r, tac_seen_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [E_W-1:0]          hw_r, off_r;
  logic signed [WIN_W-1:0] ref_r, lo_r, hi_r;
  logic [E_W-1:0]          tac_e_r;
  logic [RW-1:0]           rot_r, rot_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic                    out_last_r, out_user_r;

  logic [CH_W-1:0]  in_ch;
  logic [TS_W-1:0]  in_ts;
  logic [E_W-1:0]   in_e, in_es;
  logic             accept, is_det, is_tac, store, full;
  hit_t             new_hit, head, wrap_hit;
  hit_t             cell_q [DEPTH];
  cell_ctl_t        ctl [DEPTH];
  logic             seen0, seen1, more_match;
  logic             out_free, step, emit;
  logic             cfg_wr;

  assign in_ch = in_tdata[3:0];
  assign in_ts = in_tdata[51:4];
  assign in_e  = in_tdata[67:52];
  assign in_es = in_tdata[83:68];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_det    = (in_ch == CH_DET0) || (in_ch == CH_DET1);
  assign is_tac    = (in_ch == CH_TAC);
  assign store     = accept && is_det;
  assign full      = !tac_seen_r && (count_r == CW'(DEPTH));

  always_comb begin
    new_hit              = '0;
    new_hit.ch           = in_ch[0];
    new_hit.time_v       = in_ts;
    new_hit.energy       = in_e;
    new_hit.short_energy = in_es;
  end

  assign head = cell_q[0];

  always_comb begin
    wrap_hit       = head;
    wrap_hit.match = 1'b0;
  end

  assign out_free = !out_valid_r || out_tready;
  assign step     = (state_r == S_EMIT) && (!head.match || out_free);
  assign emit     = (state_r == S_EMIT) && head.match && out_free;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].calc = (state_r == S_CALC);
      ctl[i].take = step || (store && full && (i < DEPTH - 1));
      if (full) begin
        ctl[i].load = store && (i == DEPTH - 1);
      end else if (tac_seen_r) begin
        ctl[i].load = store && (i == 0);
      end else begin
        ctl[i].load = store && (count_r == CW'(i));
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    hit_t nbr;
    if (g == DEPTH - 1) begin : g_top
      assign nbr = wrap_hit;
    end else begin : g_mid
      assign nbr = cell_q[g + 1];
    end
    tcb_cell u_cell (
      .clk     (clk),
      .ctl     (ctl[g]),
      .valid   (CW'(g) < count_r),
      .new_hit (new_hit),
      .nbr_hit (nbr),
      .win_lo  (lo_r),
      .win_hi  (hi_r),
      .hit_q   (cell_q[g])
    );
  end

  always_comb begin
    seen0      = 1'b0;
    seen1      = 1'b0;
    more_match = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      seen0 = seen0 | (cell_q[i].match & !cell_q[i].ch);
      seen1 = seen1 | (cell_q[i].match & cell_q[i].ch);
      if (i > 0) begin
        more_match = more_match | cell_q[i].match;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    tac_seen_nxt = tac_seen_r;
    ovf_nxt      = ovf_r;
    rot_nxt      = rot_r;
    idx_nxt      = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (store) begin
          tac_seen_nxt = 1'b0;
          if (tac_seen_r) begin
            count_nxt = CW'(1);
            ovf_nxt   = 1'b0;
          end else if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end else if (accept && is_tac) begin
          tac_seen_nxt = 1'b1;
          state_nxt    = S_WIN;
        end
      end
      S_WIN:  state_nxt = S_CALC;
      S_CALC: state_nxt = S_DECIDE;
      S_DECIDE: begin
        rot_nxt   = '0;
        idx_nxt   = '0;
        state_nxt = (seen0 && seen1) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (step) begin
          rot_nxt = rot_r + RW'(1);
          if (rot_r == RW'(DEPTH - 1)) begin
            state_nxt = S_IDLE;
          end
        end
        if (emit) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tac_seen_r  <= 1'b0;
      ovf_r       <= 1'b0;
      rot_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tac_seen_r  <= tac_seen_nxt;
      ovf_r       <= ovf_nxt;
      rot_r       <= rot_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_tac) begin
      ref_r   <= $signed({2'b00, in_ts}) + $signed({{(WIN_W-E_W){off_r[E_W-1]}}, off_r});
      tac_e_r <= in_e;
    end
    if (state_r == S_WIN) begin
      lo_r <= ref_r - $signed({{(WIN_W-E_W){1'b0}}, hw_r});
      hi_r <= ref_r + $signed({{(WIN_W-E_W){1'b0}}, hw_r});
    end
    if (emit) begin
      out_data_r <= {3'b000, idx_r, head.short_energy, head.energy, head.time_v,
                     head.ch, tac_e_r};
      out_last_r <= !more_match;
      out_user_r <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r  <= HALF_WIDTH_RST;
      off_r <= OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_HALF_WIDTH: hw_r  <= cfg_pwdata[E_W-1:0];
        REG_OFFSET:     off_r <= cfg_pwdata[E_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_HALF_WIDTH: cfg_prdata = {{(APB_W-E_W){1'b0}}, hw_r};
      REG_OFFSET:     cfg_prdata = {{(APB_W-E_W){1'b0}}, off_r};
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/tcb_cell.sv @@
module tcb_cell (
  input  logic                              clk,
  input  tcb_pkg::cell_ctl_t                ctl,
  input  logic                              valid,
  input  tcb_pkg::hit_t                     new_hit,
  input  tcb_pkg::hit_t                     nbr_hit,
  input  logic signed [tcb_pkg::WIN_W-1:0]  win_lo,
  input  logic signed [tcb_pkg::WIN_W-1:0]  win_hi,
  output tcb_pkg::hit_t                     hit_q
);
  import tcb_pkg::*;

  hit_t               hit_r;
  logic signed [WIN_W-1:0] t_s;
  logic               in_win;

  assign t_s    = $signed({2'b00, hit_r.time_v});
  assign in_win = valid && (t_s > win_lo) && (t_s < win_hi);
  assign hit_q  = hit_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hit_r <= new_hit;
    end else if (ctl.take) begin
      hit_r <= nbr_hit;
    end else if (ctl.calc) begin
      hit_r.match <= in_win;
    end
  end

endmodule

@@ rtl/core/tcb_checker.sv @@
module tcb_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [tcb_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tcb_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tcb_pkg::*;

  logic tac_req;
  logic other_req;

  assign tac_req   = in_tvalid && in_tready && (in_tdata[3:0] == CH_TAC);
  assign other_req = in_tvalid && in_tready && (in_tdata[3:0] != CH_TAC);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Nothing is pending straight after reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A TAC request starts a scan, so the input is held off next cycle.
  a_tac_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tac_req |=> !in_tready)
    else $error("input ready during a scan");

  // Any other request leaves the input ready.
  a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
    other_req |=> in_tready)
    else $error("detector hit took more than one cycle");

endmodule

bind timestamp_coincidence_builder_top tcb_checker u_tcb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/timestamp_coincidence_builder_top_test.sv @@
`timescale 1ns / 1ps

module timestamp_coincidence_builder_top_test;
  import tcb_pkg::*;

  localparam int DEPTH = 16;
  localparam int SETTLE_CYCLES = 4 + DEPTH + 20;
  localparam int STALL_LIMIT = 4000;
  localparam logic [ADDR_W-1:0] ADDR_HALF_WIDTH = {REG_HALF_WIDTH, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_OFFSET     = {REG_OFFSET, 2'b00};
  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  typedef struct {
    logic [E_W-1:0]   tac_energy;
    logic             hit_channel;
    logic [TS_W-1:0]  hit_ts;
    logic [E_W-1:0]   hit_energy;
    logic [E_W-1:0]   hit_short;
    logic [IDX_W-1:0] hit_index;
    logic             last_hit;
    logic             dropped;
  } coinc_hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_W-1:0] cfg_pwdata = '0;
  logic [APB_W-1:0] cfg_prdata;
  logic cfg_pready;

  // Copy of the hit ring and window settings used for prediction.
  logic [TS_W-1:0] ring_ts [DEPTH];
  logic [E_W-1:0]  ring_energy [DEPTH];
  logic [E_W-1:0]  ring_short [DEPTH];
  logic            ring_ch [DEPTH];
  int unsigned     ring_head = 0;
  int unsigned     ring_count = 0;
  bit              tac_done = 1'b0;
  bit              ring_overflowed = 1'b0;
  logic [E_W-1:0]  win_half = HALF_WIDTH_RST;
  logic signed [E_W-1:0] win_offset = OFFSET_RST;

  coinc_hit_t coinc_queue [$];
  int error_count = 0;
  int hits_sent = 0;
  int tacs_sent = 0;
  int results_seen = 0;
  int windows_built = 0;
  int stall_cycles = 0;
  bit idle_on = 1'b1;
  int hold_len = 0;

  timestamp_coincidence_builder_top #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  function automatic void build_coincidence(logic [CH_W-1:0] ch, logic [TS_W-1:0] ts,
                                            logic [E_W-1:0] e, logic [E_W-1:0] se);
    int unsigned slot;
    int unsigned matched [$];
    bit seen0;
    bit seen1;
    longint centre;
    longint d;
    coinc_hit_t r;
    seen0 = 1'b0;
    seen1 = 1'b0;
    if (ch == CH_DET0 || ch == CH_DET1) begin
      if (tac_done) begin
        tac_done = 1'b0;
        ring_head = 0;
        ring_count = 0;
        ring_overflowed = 1'b0;
      end
      if (ring_count >= DEPTH) begin
        slot = ring_head;
        ring_head = (ring_head + 1) % DEPTH;
        ring_overflowed = 1'b1;
      end else begin
        slot = (ring_head + ring_count) % DEPTH;
        ring_count++;
      end
      ring_ts[slot] = ts;
      ring_energy[slot] = e;
      ring_short[slot] = se;
      ring_ch[slot] = ch[0];
      return;
    end
    if (ch != CH_TAC) return;
    tac_done = 1'b1;
    centre = longint'(ts) + longint'(win_offset);
    for (int k = 0; k < ring_count; k++) begin
      slot = (ring_head + k) % DEPTH;
      d = longint'(ring_ts[slot]) - centre;
      if (d < 0) d = -d;
      if (d < longint'(win_half)) begin
        matched.push_back(slot);
        if (ring_ch[slot]) seen1 = 1'b1;
        else seen0 = 1'b1;
      end
    end
    if (!(seen0 && seen1)) return;
    windows_built++;
    foreach (matched[k]) begin
      r.tac_energy = e;
      r.hit_channel = ring_ch[matched[k]];
      r.hit_ts = ring_ts[matched[k]];
      r.hit_energy = ring_energy[matched[k]];
      r.hit_short = ring_short[matched[k]];
      r.hit_index = IDX_W'(k);
      r.last_hit = (k == matched.size() - 1);
      r.dropped = ring_overflowed;
      coinc_queue.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (coinc_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
        error_count++;
      end else begin
        coinc_hit_t w;
        w = coinc_queue.pop_front();
        check_field("tac_energy", 64'(w.tac_energy), 64'(out_tdata[15:0]));
        check_field("hit_channel", 64'(w.hit_channel), 64'(out_tdata[16]));
        check_field("hit_time", 64'(w.hit_ts), 64'(out_tdata[64:17]));
        check_field("hit_energy", 64'(w.hit_energy), 64'(out_tdata[80:65]));
        check_field("hit_short_energy", 64'(w.hit_short), 64'(out_tdata[96:81]));
        check_field("hit_index", 64'(w.hit_index), 64'(out_tdata[100:97]));
        check_field("last_hit", 64'(w.last_hit), 64'(out_tlast));
        check_field("hits_dropped", 64'(w.dropped), 64'(out_tuser));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: waits a random number of cycles before each result while idle_on
  // is set, or a long hold-off when one has been asked for.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      n = idle_on ? $urandom_range(0, 16) : 0;
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_hit(logic [CH_W-1:0] ch, logic [TS_W-1:0] ts,
                          logic [E_W-1:0] e, logic [E_W-1:0] se);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) != 0) ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {4'b0, se, e, ts, ch};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    build_coincidence(ch, ts, e, se);
    hits_sent++;
    if (ch == CH_TAC) tacs_sent++;
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (coinc_queue.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [E_W-1:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= {{(APB_W-E_W){1'b0}}, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_HALF_WIDTH) win_half = val;
    else win_offset = val;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic read_reg(logic [ADDR_W-1:0] addr, logic [E_W-1:0] want);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("register read", 64'(want), 64'(cfg_prdata[E_W-1:0]));
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_window(logic [E_W-1:0] half, logic [E_W-1:0] offs);
    quiesce();
    write_reg(ADDR_HALF_WIDTH, half);
    write_reg(ADDR_OFFSET, offs);
    read_reg(ADDR_HALF_WIDTH, half);
    read_reg(ADDR_OFFSET, offs);
  endtask

  // One acquisition window: detector hits placed around the TAC time plus
  // offset, mostly inside the window, some on its edge or far outside,
  // with hits on ignored channels mixed in.
  task automatic send_window(int n_det, int n_tac);
    logic [TS_W-1:0] tac_ts;
    longint centre;
    longint d;
    int hw;
    int r;
    bit one_sided;
    logic [CH_W-1:0] ch;
    tac_ts = TS_W'({$urandom(), $urandom()});
    centre = longint'(tac_ts) + longint'(win_offset);
    hw = int'(win_half);
    one_sided = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < n_det; i++) begin
      r = $urandom_range(0, 9);
      if (r < 7) d = (hw == 0) ? 0 : longint'($urandom_range(0, 2 * hw - 2)) - (hw - 1);
      else if (r == 7) d = longint'($urandom_range(0, 1) ? hw : -hw);
      else d = longint'(int'($urandom()));
      ch = one_sided ? CH_DET0 : (i < 2 ? CH_W'(i) : CH_W'($urandom_range(0, 1)));
      send_hit(ch, TS_W'(centre + d), E_W'($urandom()), E_W'($urandom()));
      if ($urandom_range(0, 7) == 0)
        send_hit(CH_W'($urandom_range(3, 15)), TS_W'({$urandom(), $urandom()}),
                 E_W'($urandom()), E_W'($urandom()));
    end
    for (int i = 0; i < n_tac; i++) send_hit(CH_TAC, tac_ts, E_W'($urandom()), E_W'($urandom()));
  endtask

  task automatic test_register_access();
    read_reg(ADDR_HALF_WIDTH, HALF_WIDTH_RST);
    read_reg(ADDR_OFFSET, OFFSET_RST);
  endtask

  task automatic test_directed_extremes();
    // Window centred at time zero: hits inside it and one on its upper edge.
    send_hit(CH_DET0, '0, '0, '0);
    send_hit(CH_DET1, 48'd49, '1, '1);
    send_hit(CH_DET0, 48'd50, 16'h1234, 16'h8001);
    send_hit(CH_TAC, 48'd300, '1, '0);
    // Top of the timestamp range, with a repeated TAC hit.
    send_hit(CH_DET1, TS_MAX - 48'd300, 16'h8000, 16'h7FFF);
    send_hit(CH_DET0, TS_MAX - 48'd251, 16'h0001, 16'hFFFE);
    send_hit(CH_DET1, TS_MAX - 48'd350, 16'hAAAA, 16'h5555);
    send_hit(CH_DET0, TS_MAX, 16'h5555, 16'hAAAA);
    send_hit(CH_TAC, TS_MAX, '0, '1);
    send_hit(CH_TAC, TS_MAX, 16'hBEEF, 16'h0);
    // Matches on one channel only give no coincidence.
    send_hit(CH_DET0, 48'd1000, 16'd7, 16'd3);
    send_hit(CH_DET0, 48'd1010, 16'd8, 16'd4);
    send_hit(CH_TAC, 48'd1300, 16'd99, 16'd0);
    // Ignored channels change nothing.
    send_hit(4'd15, TS_MAX, '1, '1);
    send_hit(4'd3, '0, '0, '0);
    send_hit(CH_DET1, 48'd1005, 16'd9, 16'd5);
    send_hit(4'd8, 48'd1305, '1, '1);
    send_hit(CH_DET0, 48'd1001, 16'd10, 16'd6);
    send_hit(CH_TAC, 48'd1302, 16'd77, 16'd1);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < DEPTH + 1; i++)
      send_hit(CH_W'(i % 2), 48'd50000 + 48'(i), E_W'($urandom()), E_W'($urandom()));
    send_hit(CH_TAC, 48'd50308, 16'h0F0F, 16'h0);
    send_hit(CH_DET0, 48'd60000, 16'd1, 16'd1);
    send_hit(CH_DET1, 48'd60001, 16'd2, 16'd2);
    send_hit(CH_TAC, 48'd60300, 16'hF0F0, 16'h0);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_len = 400;
    for (int i = 0; i < 3; i++) send_window(12, 1);
    quiesce();
    idle_on = 1'b1;
  endtask

  task automatic test_random_windows();
    logic [E_W-1:0] halves [6];
    logic [E_W-1:0] offsets [6];
    int start;
    halves = '{16'd50, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0};
    offsets = '{16'hFED4, 16'd0, 16'h8000, 16'h7FFF, 16'd0, 16'd0};
    halves[5] = E_W'($urandom_range(2, 2000));
    offsets[5] = E_W'($urandom());
    for (int p = 0; p < 6; p++) begin
      set_window(halves[p], offsets[p]);
      idle_on = (p != 2);
      start = hits_sent;
      while (hits_sent - start < 25) send_window($urandom_range(2, 8), $urandom_range(0, 3) == 0 ? 2 : 1);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_directed_extremes();
    test_overflow();
    test_backpressure();
    test_random_windows();
    quiesce();
    $display("Sent %0d hit requests including %0d TAC hits over several window settings,",
             hits_sent, tacs_sent);
    $display("checked %0d results from %0d coincidences, with overflow and a long stall.",
             results_seen, windows_built);
    if (error_count == 0 && coinc_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
